/* hw/rtl/steq_pkg.sv */
`default_nettype none

package steq_pkg;

  // Fixed field widths
  localparam int TIME_W   = 31;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF        = 16;
  localparam int LISTENER_IDS_DEF = 256;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP        = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

  // Per-cycle operation broadcast to every cell
  localparam int CELL_OP_W = 3;
  localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 3'd0;
  localparam logic [CELL_OP_W-1:0] CELL_INSERT = 3'd1;
  localparam logic [CELL_OP_W-1:0] CELL_POP    = 3'd2;
  localparam logic [CELL_OP_W-1:0] CELL_MARK   = 3'd3;
  localparam logic [CELL_OP_W-1:0] CELL_SCAN   = 3'd4;
  localparam logic [CELL_OP_W-1:0] CELL_SORT   = 3'd5;

  typedef struct packed {
    logic [CELL_OP_W-1:0] op;
    logic                 odd_round;  // odd-even sort phase
    logic                 allow;      // a match may still be removed
    logic                 exact;      // match on time as well as listener
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/steq_if.sv */
`default_nettype none

// Command channel
interface steq_in_if #(
  parameter int LIS_W = $clog2(steq_pkg::LISTENER_IDS_DEF)
);
  logic                         valid;
  logic                         ready;
  logic [steq_pkg::CMD_W-1:0]   cmd;
  logic [steq_pkg::TIME_W-1:0]  due_time;
  logic [LIS_W-1:0]             listener_id;

  modport source(output valid, cmd, due_time, listener_id, input ready);
  modport sink(input valid, cmd, due_time, listener_id, output ready);
endinterface

// Result channel
interface steq_out_if #(
  parameter int LIS_W = $clog2(steq_pkg::LISTENER_IDS_DEF),
  parameter int CNT_W = $clog2(steq_pkg::DEPTH_DEF + 1)
);
  logic                           valid;
  logic                           ready;
  logic [steq_pkg::STATUS_W-1:0]  status;
  logic                           head_valid;
  logic [steq_pkg::TIME_W-1:0]    head_time;
  logic [LIS_W-1:0]               head_listener;
  logic [CNT_W-1:0]               entry_count;

  modport source(output valid, status, head_valid, head_time, head_listener, entry_count,
                 input ready);
  modport sink(input valid, status, head_valid, head_time, head_listener, entry_count,
               output ready);
endinterface

`default_nettype wire

/* hw/rtl/steq_cell.sv */
`default_nettype none

module steq_cell #(
  parameter int DEPTH = steq_pkg::DEPTH_DEF,
  parameter int LIS_W = $clog2(steq_pkg::LISTENER_IDS_DEF),
  parameter int IDX   = 0,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire steq_pkg::cell_ctl_t         ctl,
  input  wire logic [steq_pkg::TIME_W-1:0] key_time,
  input  wire logic [LIS_W-1:0]            key_lis,
  input  wire logic [CNT_W-1:0]            count,
  // neighbor below (toward the head)
  input  wire logic [steq_pkg::TIME_W-1:0] lo_time,
  input  wire logic [LIS_W-1:0]            lo_lis,
  input  wire logic                        lo_lt,
  input  wire logic                        lo_live,
  input  wire logic                        lo_tok,
  // neighbor above (toward the tail)
  input  wire logic [steq_pkg::TIME_W-1:0] up_time,
  input  wire logic [LIS_W-1:0]            up_lis,
  input  wire logic                        up_live,
  // own state toward the neighbors
  output logic [steq_pkg::TIME_W-1:0]      slot_time,
  output logic [LIS_W-1:0]                 slot_lis,
  output logic                             lt,
  output logic                             live,
  output logic                             tok,
  output logic                             kill
);

  localparam logic ODD_IDX = 1'(IDX % 2);
  localparam logic FIRST   = (IDX == 0);

  logic [steq_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [LIS_W-1:0]            lis_r, lis_nxt;
  logic                        live_r, live_nxt;
  logic                        tok_r, tok_nxt;
  logic                        occ;
  logic                        match;

  assign occ   = CNT_W'(IDX) < count;
  assign lt    = occ && (time_r < key_time);
  assign match = live_r && (lis_r == key_lis) && (!ctl.exact || (time_r == key_time));
  assign kill  = (ctl.op == steq_pkg::CELL_SCAN) && tok_r && match && ctl.allow;

  assign slot_time = time_r;
  assign slot_lis  = lis_r;
  assign live      = live_r;
  assign tok       = tok_r;

  // Next state of this slot
  always_comb begin
    time_nxt = time_r;
    lis_nxt  = lis_r;
    live_nxt = live_r;
    tok_nxt  = 1'b0;
    case (ctl.op)
      steq_pkg::CELL_INSERT: begin
        // entries before the insert point stay, the rest move up one
        if (!lt) begin
          if (lo_lt) begin
            time_nxt = key_time;
            lis_nxt  = key_lis;
          end else begin
            time_nxt = lo_time;
            lis_nxt  = lo_lis;
          end
        end
      end
      steq_pkg::CELL_POP: begin
        time_nxt = up_time;
        lis_nxt  = up_lis;
      end
      steq_pkg::CELL_MARK: begin
        live_nxt = occ;
        tok_nxt  = FIRST;
      end
      steq_pkg::CELL_SCAN: begin
        // token walks toward the tail, one slot a cycle
        tok_nxt = lo_tok;
        if (kill) begin
          live_nxt = 1'b0;
        end
      end
      steq_pkg::CELL_SORT: begin
        // odd-even transposition: dead slots bubble toward the tail
        if (ODD_IDX == ctl.odd_round) begin
          if (!live_r && up_live) begin
            time_nxt = up_time;
            lis_nxt  = up_lis;
            live_nxt = 1'b1;
          end
        end else if (!lo_live && live_r) begin
          live_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    lis_r  <= lis_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      live_r <= live_nxt;
      tok_r  <= tok_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/steq_ctrl.sv */
`default_nettype none

module steq_ctrl #(
  parameter int DEPTH = steq_pkg::DEPTH_DEF,
  parameter int LIS_W = $clog2(steq_pkg::LISTENER_IDS_DEF),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  steq_in_if.sink                          in_chan,
  steq_out_if.source                       out_chan,
  output steq_pkg::cell_ctl_t              ctl,
  output logic [steq_pkg::TIME_W-1:0]      key_time,
  output logic [LIS_W-1:0]                 key_lis,
  output logic [CNT_W-1:0]                 count,
  input  wire logic                        kill_any,
  input  wire logic [steq_pkg::TIME_W-1:0] head_time,
  input  wire logic [LIS_W-1:0]            head_lis
);

  localparam int STEP_W = $clog2(DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SORT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic [steq_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [steq_pkg::TIME_W-1:0]   key_time_r, key_time_nxt;
  logic [LIS_W-1:0]              key_lis_r, key_lis_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [steq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                          found_r, found_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [steq_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_head_valid_r;
  logic [steq_pkg::TIME_W-1:0]   out_head_time_r;
  logic [LIS_W-1:0]              out_head_lis_r;
  logic [CNT_W-1:0]              out_count_r;
  logic                          in_beat;
  logic                          out_load;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_beat       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);

  assign key_time = key_time_r;
  assign key_lis  = key_lis_r;
  assign count    = count_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd_nxt       = cmd_r;
    key_time_nxt  = key_time_r;
    key_lis_nxt   = key_lis_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    ctl.op        = steq_pkg::CELL_HOLD;
    ctl.odd_round = step_r[0];
    ctl.exact     = (cmd_r == steq_pkg::CMD_REMOVE);
    ctl.allow     = !((cmd_r == steq_pkg::CMD_REMOVE) && found_r);
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          cmd_nxt      = in_chan.cmd;
          key_time_nxt = in_chan.due_time;
          key_lis_nxt  = in_chan.listener_id;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = steq_pkg::STAT_DONE;
        state_nxt  = S_FIN;
        case (cmd_r)
          steq_pkg::CMD_INSERT: begin
            if (count_r == FULL_CNT) begin
              status_nxt = steq_pkg::STAT_FULL;
            end else begin
              ctl.op    = steq_pkg::CELL_INSERT;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          steq_pkg::CMD_REMOVE, steq_pkg::CMD_REMOVE_ALL: begin
            ctl.op     = steq_pkg::CELL_MARK;
            status_nxt = steq_pkg::STAT_NOT_FOUND;
            found_nxt  = 1'b0;
            step_nxt   = '0;
            state_nxt  = S_SCAN;
          end
          steq_pkg::CMD_POP: begin
            if (count_r == '0) begin
              status_nxt = steq_pkg::STAT_EMPTY;
            end else begin
              ctl.op    = steq_pkg::CELL_POP;
              count_nxt = count_r - CNT_W'(1);
            end
          end
          steq_pkg::CMD_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        ctl.op = steq_pkg::CELL_SCAN;
        if (kill_any) begin
          count_nxt  = count_r - CNT_W'(1);
          found_nxt  = 1'b1;
          status_nxt = steq_pkg::STAT_DONE;
        end
        if (step_r == LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = S_SORT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_SORT: begin
        ctl.op = steq_pkg::CELL_SORT;
        if (step_r == LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_time_r <= key_time_nxt;
    key_lis_r  <= key_lis_nxt;
    status_r   <= status_nxt;
    if (out_load) begin
      out_status_r     <= status_r;
      out_head_valid_r <= (count_r != '0);
      out_head_time_r  <= (count_r != '0) ? head_time : '0;
      out_head_lis_r   <= (count_r != '0) ? head_lis : '0;
      out_count_r      <= count_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.head_valid    = out_head_valid_r;
  assign out_chan.head_time     = out_head_time_r;
  assign out_chan.head_listener = out_head_lis_r;
  assign out_chan.entry_count   = out_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_kill_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    kill_any |-> (state_r == S_SCAN))
    else $error("slot removed outside the scan");

  a_exact_once: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && (cmd_r == steq_pkg::CMD_REMOVE) && found_r) |-> !kill_any)
    else $error("exact remove took out more than one slot");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result load lost");

endmodule

`default_nettype wire

/* hw/rtl/sorted_timer_event_queue.sv */
// Sorted timer queue: up to DEPTH (time, listener) entries held in a row of cells in
// ascending time order, cell 0 the head. Every command beat yields one result beat with
// status, head entry and count. Insert, pop, clear and unused codes go from accept
// through an execute state to the result (insert and pop shift the whole row at once).
// Both removes first let a token walk the row one cell a cycle marking matches, then
// DEPTH rounds of odd-even transposition between neighbor cells close the gaps. A new
// command is taken as soon as the result is in the output register, while that result
// still waits for the sink.
`default_nettype none

module sorted_timer_event_queue #(
  parameter int DEPTH        = steq_pkg::DEPTH_DEF,
  parameter int LISTENER_IDS = steq_pkg::LISTENER_IDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  steq_in_if.sink    in_chan,
  steq_out_if.source out_chan
);

  localparam int LIS_W = $clog2(LISTENER_IDS);
  localparam int CNT_W = $clog2(DEPTH + 1);

  steq_pkg::cell_ctl_t         ctl;
  logic [steq_pkg::TIME_W-1:0] key_time;
  logic [LIS_W-1:0]            key_lis;
  logic [CNT_W-1:0]            count;
  logic [steq_pkg::TIME_W-1:0] time_w [DEPTH];
  logic [LIS_W-1:0]            lis_w  [DEPTH];
  logic [DEPTH-1:0]            lt_w;
  logic [DEPTH-1:0]            live_w;
  logic [DEPTH-1:0]            tok_w;
  logic [DEPTH-1:0]            kill_w;

  steq_ctrl #(
    .DEPTH (DEPTH),
    .LIS_W (LIS_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .ctl       (ctl),
    .key_time  (key_time),
    .key_lis   (key_lis),
    .count     (count),
    .kill_any  (|kill_w),
    .head_time (time_w[0]),
    .head_lis  (lis_w[0])
  );

  // Row of slot cells, each wired to its two neighbors
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [steq_pkg::TIME_W-1:0] lo_time, up_time;
    logic [LIS_W-1:0]            lo_lis, up_lis;
    logic                        lo_lt, lo_live, lo_tok, up_live;

    if (gi == 0) begin : g_lo_end
      // head end: insert lands here, never a sort partner below
      assign lo_time = '0;
      assign lo_lis  = '0;
      assign lo_lt   = 1'b1;
      assign lo_live = 1'b1;
      assign lo_tok  = 1'b0;
    end else begin : g_lo
      assign lo_time = time_w[gi-1];
      assign lo_lis  = lis_w[gi-1];
      assign lo_lt   = lt_w[gi-1];
      assign lo_live = live_w[gi-1];
      assign lo_tok  = tok_w[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_up_end
      // tail end: nothing moves in from above
      assign up_time = '0;
      assign up_lis  = '0;
      assign up_live = 1'b0;
    end else begin : g_up
      assign up_time = time_w[gi+1];
      assign up_lis  = lis_w[gi+1];
      assign up_live = live_w[gi+1];
    end

    steq_cell #(
      .DEPTH (DEPTH),
      .LIS_W (LIS_W),
      .IDX   (gi)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key_time  (key_time),
      .key_lis   (key_lis),
      .count     (count),
      .lo_time   (lo_time),
      .lo_lis    (lo_lis),
      .lo_lt     (lo_lt),
      .lo_live   (lo_live),
      .lo_tok    (lo_tok),
      .up_time   (up_time),
      .up_lis    (up_lis),
      .up_live   (up_live),
      .slot_time (time_w[gi]),
      .slot_lis  (lis_w[gi]),
      .lt        (lt_w[gi]),
      .live      (live_w[gi]),
      .tok       (tok_w[gi]),
      .kill      (kill_w[gi])
    );
  end

endmodule

`default_nettype wire

/* dv/tb_sorted_timer_event_queue.sv */
`default_nettype none

module tb_sorted_timer_event_queue;

  localparam int TIME_W   = steq_pkg::TIME_W;
  localparam int CMD_W    = steq_pkg::CMD_W;
  localparam int STATUS_W = steq_pkg::STATUS_W;
  localparam int DEPTH = steq_pkg::DEPTH_DEF;
  localparam int LIS_W = $clog2(steq_pkg::LISTENER_IDS_DEF);
  localparam int CNT_W = $clog2(steq_pkg::DEPTH_DEF + 1);
  localparam int CMD_TARGET = 1450;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [LIS_W-1:0] LIS_MAX = '1;
  // codes 5..7 are not decoded by the block
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = steq_pkg::CMD_CLEAR + 1'b1;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] due_time;
    logic [LIS_W-1:0]  listener_id;
  } timer_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                head_valid;
    logic [TIME_W-1:0]   head_time;
    logic [LIS_W-1:0]    head_listener;
    logic [CNT_W-1:0]    entry_count;
  } queue_report_t;

  logic clk;
  logic rst_n;

  steq_in_if  in_bus ();
  steq_out_if out_bus ();

  sorted_timer_event_queue i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Commands still to send and reports still owed by the block
  timer_cmd_t    queued_cmds[$];
  queue_report_t pending_reports[$];

  // Shadow copy of the sorted entry list
  logic [TIME_W-1:0] shadow_time[DEPTH];
  logic [LIS_W-1:0]  shadow_listener[DEPTH];
  int                shadow_count = 0;

  int errors = 0;
  int accepted_cmds = 0;
  int returned_reports = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int hold_left = 0;
  bit hold_used = 1'b0;

  // Close the gap left by one entry
  function automatic void drop_entry(int idx);
    int k;
    for (k = idx; k + 1 < shadow_count; k++) begin
      shadow_time[k] = shadow_time[k + 1];
      shadow_listener[k] = shadow_listener[k + 1];
    end
    shadow_count--;
  endfunction

  // Apply one command to the shadow list and return the report it must produce
  function automatic queue_report_t apply_timer_cmd(timer_cmd_t c);
    queue_report_t r;
    int pos;
    int k;
    int wr;
    bit hit;
    r = '0;
    r.status = steq_pkg::STAT_DONE;
    case (c.cmd)
      steq_pkg::CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = steq_pkg::STAT_FULL;
        end else begin
          // new entry lands ahead of entries with the same time
          pos = 0;
          while (pos < shadow_count && shadow_time[pos] < c.due_time) pos++;
          for (k = shadow_count; k > pos; k--) begin
            shadow_time[k] = shadow_time[k - 1];
            shadow_listener[k] = shadow_listener[k - 1];
          end
          shadow_time[pos] = c.due_time;
          shadow_listener[pos] = c.listener_id;
          shadow_count++;
        end
      end
      steq_pkg::CMD_REMOVE: begin
        pos = -1;
        for (k = 0; k < shadow_count && shadow_time[k] <= c.due_time; k++) begin
          if (pos < 0 && shadow_time[k] == c.due_time && shadow_listener[k] == c.listener_id)
            pos = k;
        end
        if (pos >= 0) drop_entry(pos);
        else r.status = steq_pkg::STAT_NOT_FOUND;
      end
      steq_pkg::CMD_REMOVE_ALL: begin
        wr = 0;
        hit = 1'b0;
        for (k = 0; k < shadow_count; k++) begin
          if (shadow_listener[k] == c.listener_id) begin
            hit = 1'b1;
          end else begin
            shadow_time[wr] = shadow_time[k];
            shadow_listener[wr] = shadow_listener[k];
            wr++;
          end
        end
        shadow_count = wr;
        if (!hit) r.status = steq_pkg::STAT_NOT_FOUND;
      end
      steq_pkg::CMD_POP: begin
        if (shadow_count == 0) r.status = steq_pkg::STAT_EMPTY;
        else drop_entry(0);
      end
      steq_pkg::CMD_CLEAR: shadow_count = 0;
      default: ;
    endcase
    if (shadow_count > 0) begin
      r.head_valid = 1'b1;
      r.head_time = shadow_time[0];
      r.head_listener = shadow_listener[0];
    end
    r.entry_count = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Sender: counts accepted beats, then offers the next command
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        pending_reports.push_back(apply_timer_cmd('{in_bus.cmd, in_bus.due_time,
                                                    in_bus.listener_id}));
        accepted_cmds++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        // idle now and then, but never inside the calm window
        if (queued_cmds.size() > 0 &&
            ((accepted_cmds >= 600 && accepted_cmds < 850) || $urandom_range(0, 99) >= 13)) begin
          in_bus.cmd <= queued_cmds[0].cmd;
          in_bus.due_time <= queued_cmds[0].due_time;
          in_bus.listener_id <= queued_cmds[0].listener_id;
          in_bus.valid <= 1'b1;
          void'(queued_cmds.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_used <= 1'b0;
      hold_left <= 0;
    end else if (!hold_used && returned_reports >= 300) begin
      hold_used <= 1'b1;
      hold_left <= 250;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each result beat and steers ready
  always @(posedge clk) begin
    queue_report_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, expected none actual %0h",
                   $time, out_bus.status);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("status", 32'(want.status), 32'(out_bus.status));
          check_field("head_valid", 32'(want.head_valid), 32'(out_bus.head_valid));
          check_field("head_time", 32'(want.head_time), 32'(out_bus.head_time));
          check_field("head_listener", 32'(want.head_listener), 32'(out_bus.head_listener));
          check_field("entry_count", 32'(want.entry_count), 32'(out_bus.entry_count));
        end
        status_seen[out_bus.status]++;
        returned_reports++;
      end
      if ((!hold_used && returned_reports >= 300) || hold_left > 0) begin
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= (returned_reports >= 600 && returned_reports < 850) ||
                         ($urandom_range(0, 99) >= 13);
      end
    end
  end

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return TIME_W'($urandom_range(0, 15));
      6: return $urandom_range(0, 1) ? TIME_MAX : '0;
      default: return TIME_W'($urandom());
    endcase
  endfunction

  function automatic logic [LIS_W-1:0] pick_listener();
    if ($urandom_range(0, 9) < 7) return LIS_W'($urandom_range(0, 3));
    return LIS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CMD_W-1:0] CMD_CMD_W_SPARE();
    return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
  endfunction

  task automatic add_cmd(logic [CMD_W-1:0] c, logic [TIME_W-1:0] t, logic [LIS_W-1:0] l);
    queued_cmds.push_back('{c, t, l});
  endtask

  // Stimulus, reset and end of run
  initial begin
    timer_cmd_t recent[$];
    timer_cmd_t pick;
    int burst;
    int mode;
    int roll;
    int n;

    rst_n = 1'b0;

    // Directed: every command on an empty list, then a short worked sequence
    add_cmd(steq_pkg::CMD_POP, '0, '0);
    add_cmd(steq_pkg::CMD_REMOVE, 31'd5, 8'd1);
    add_cmd(steq_pkg::CMD_REMOVE_ALL, '0, 8'd1);
    add_cmd(steq_pkg::CMD_CLEAR, '0, '0);
    add_cmd(CMD_SPARE_FIRST, TIME_MAX, LIS_MAX);
    add_cmd(steq_pkg::CMD_INSERT, TIME_MAX, LIS_MAX);
    add_cmd(steq_pkg::CMD_INSERT, '0, '0);
    add_cmd(steq_pkg::CMD_INSERT, 31'd100, 8'd7);
    add_cmd(steq_pkg::CMD_INSERT, 31'd100, 8'd9);   // same time, goes in front
    add_cmd(steq_pkg::CMD_INSERT, 31'd100, 8'd7);
    add_cmd(steq_pkg::CMD_REMOVE, 31'd100, 8'd7);   // only the first match leaves
    add_cmd(steq_pkg::CMD_REMOVE, 31'd100, 8'd8);   // time matches, listener does not
    add_cmd(steq_pkg::CMD_INSERT, 31'd60, 8'd7);
    add_cmd(steq_pkg::CMD_INSERT, 31'd70, 8'd7);    // neighbors of the same listener
    add_cmd(steq_pkg::CMD_REMOVE_ALL, '0, 8'd7);
    add_cmd(CMD_SPARE_LAST, 31'h2AAAAAAA, 8'h55);
    add_cmd(steq_pkg::CMD_POP, '0, '0);
    add_cmd(steq_pkg::CMD_REMOVE, TIME_MAX, LIS_MAX);
    add_cmd(steq_pkg::CMD_REMOVE_ALL, '0, 8'd200);
    add_cmd(steq_pkg::CMD_INSERT, 31'h2AAAAAAA, 8'h55);
    add_cmd(steq_pkg::CMD_INSERT, 31'h55555555, 8'hAA);
    add_cmd(steq_pkg::CMD_CLEAR, '0, '0);
    add_cmd(CMD_SPARE_FIRST + 1'b1, '0, '0);
    add_cmd(steq_pkg::CMD_POP, '0, '0);

    // Random bursts: filling runs that hit full, draining runs, mixed traffic
    while (queued_cmds.size() < CMD_TARGET) begin
      mode = $urandom_range(0, 2);
      burst = $urandom_range(10, 40);
      for (n = 0; n < burst; n++) begin
        roll = $urandom_range(0, 99);
        pick = '{steq_pkg::CMD_INSERT, pick_time(), pick_listener()};
        if (mode == 0) begin
          if (roll >= 85) pick.cmd = steq_pkg::CMD_POP;
        end else if (mode == 1) begin
          if (roll < 40) pick.cmd = steq_pkg::CMD_POP;
          else if (roll < 70) pick.cmd = steq_pkg::CMD_REMOVE;
          else if (roll < 95) pick.cmd = steq_pkg::CMD_REMOVE_ALL;
        end else begin
          if (roll < 45) pick.cmd = steq_pkg::CMD_INSERT;
          else if (roll < 65) pick.cmd = steq_pkg::CMD_REMOVE;
          else if (roll < 75) pick.cmd = steq_pkg::CMD_REMOVE_ALL;
          else if (roll < 90) pick.cmd = steq_pkg::CMD_POP;
          else if (roll < 93) pick.cmd = steq_pkg::CMD_CLEAR;
          else if (roll < 96) pick.cmd = CMD_CMD_W_SPARE();
          else pick.cmd = steq_pkg::CMD_REMOVE;  // random pair, mostly a miss
        end
        // removes usually aim at something inserted earlier
        if (pick.cmd == steq_pkg::CMD_REMOVE && roll < 90 && recent.size() > 0) begin
          pick = recent[$urandom_range(0, recent.size() - 1)];
          pick.cmd = steq_pkg::CMD_REMOVE;
        end else if (pick.cmd == steq_pkg::CMD_REMOVE_ALL && recent.size() > 0 && roll[0]) begin
          pick.listener_id = recent[$urandom_range(0, recent.size() - 1)].listener_id;
        end
        if (pick.cmd == steq_pkg::CMD_INSERT) begin
          recent.push_back(pick);
          if (recent.size() > 32) void'(recent.pop_front());
        end
        queued_cmds.push_back(pick);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_cmds.size() > 0 || in_bus.valid || pending_reports.size() > 0)
      @(posedge clk);
    // let anything stray show up
    repeat (4 * DEPTH) @(posedge clk);

    $display("Sent %0d commands, checked %0d results", accepted_cmds, returned_reports);
    $display("Status counts: done %0d, not found %0d, full %0d, empty pop %0d",
             status_seen[steq_pkg::STAT_DONE], status_seen[steq_pkg::STAT_NOT_FOUND],
             status_seen[steq_pkg::STAT_FULL], status_seen[steq_pkg::STAT_EMPTY]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
